### design/tempo_ramp_table_defines.svh
// Assertion macros for the tempo ramp table.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef TEMPO_RAMP_TABLE_DEFINES_SVH
`define TEMPO_RAMP_TABLE_DEFINES_SVH

`ifndef ASSERT_OFF
`define TRT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TRT_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) pre |=> post) else $error(msg);
`else
`define TRT_ASSERT(label, clk, rst, prop, msg)
`define TRT_ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif

`endif

### design/trt_pkg.sv
// Shared types and constants for the tempo ramp table.
// No dependencies; used by trt_table, tempo_ramp_table and the testbench.
package trt_pkg;

   localparam int          MAX_RESULTS   = 16;
   localparam logic [4:0]  WHOLE_CHANNEL = 5'd16;
   localparam logic [31:0] STOPPED_START = 32'h0000_7F00;

   localparam logic FUNC_SET  = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   typedef enum logic [1:0] {
      KIND_SET_OK   = 2'd0,
      KIND_SET_DROP = 2'd1,
      KIND_UPDATE   = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SET_PREP,
      ST_SET_RD,
      ST_SET_CHK,
      ST_SET_WAIT,
      ST_SET_DROP,
      ST_TICK_RD,
      ST_TICK_UPD,
      ST_TICK_END
   } state_type;

   typedef struct packed {
      logic [1:0]  slot;
      logic [4:0]  channel;
      logic [31:0] tempo;
      logic [31:0] target;
      logic [32:0] step;
   } entry_type;

endpackage

### design/trt_if.sv
// Valid/ready channel interfaces for the tempo ramp table requests and responses.
// No dependencies.
interface trt_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [1:0]  slot;
   logic [4:0]  channel;
   logic [23:0] start_tempo;
   logic [23:0] goal_tempo;
   logic [15:0] ramp_halfframes;
   logic [3:0]  stopped_mask;

   modport source (output valid, func, slot, channel, start_tempo, goal_tempo,
                   ramp_halfframes, stopped_mask, input ready);
   modport sink (input valid, func, slot, channel, start_tempo, goal_tempo,
                 ramp_halfframes, stopped_mask, output ready);
endinterface

interface trt_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [1:0]  out_slot;
   logic [4:0]  out_channel;
   logic [23:0] new_tempo;
   logic        last;

   modport source (output valid, kind, out_slot, out_channel, new_tempo, last,
                   input ready);
   modport sink (input valid, kind, out_slot, out_channel, new_tempo, last,
                 output ready);
endinterface

### design/trt_div.sv
// Serial restoring divider, one quotient bit per cycle.
// Depends on nothing; instantiated by tempo_ramp_table.
module trt_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [15:0] divisor,
   output logic        busy,
   output logic [31:0] quotient
);

   logic        busy_ff, busy_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [15:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [15:0] div_ff, div_in;
   logic [16:0] trial;
   logic [16:0] diff;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      trial   = {rem_ff, quo_ff[31]};
      diff    = trial - {1'b0, div_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 5'd31;
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         if (!diff[16]) begin
            rem_in = diff[15:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = trial[15:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

### design/trt_table.sv
// Ramp entry memory: one write port, one registered read port, per-entry valid bits.
// Depends on trt_pkg; instantiated by tempo_ramp_table.
module trt_table #(
   parameter int NUM_ENTRIES = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [(NUM_ENTRIES > 1 ? $clog2(NUM_ENTRIES) : 1)-1:0] rd_addr,
   output trt_pkg::entry_type   rd_data,
   input  logic                 wr_en,
   input  logic [(NUM_ENTRIES > 1 ? $clog2(NUM_ENTRIES) : 1)-1:0] wr_addr,
   input  trt_pkg::entry_type   wr_data
);
   import trt_pkg::*;

   entry_type mem [NUM_ENTRIES];
   logic      valid_ff [NUM_ENTRIES];
   entry_type rd_mem_ff;
   logic      rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_mem_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            valid_ff[i] <= 1'b0;
         end
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_vld_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_vld_ff ? rd_mem_ff : '0;

endmodule

### design/tempo_ramp_table.sv
// Tempo ramp table top level: sequencer, tick update and response register.
// Depends on trt_pkg, trt_if, trt_div, trt_table and tempo_ramp_table_defines.svh.
//
//   port       dir   role
//   req_chan   sink  set or tick requests
//   rsp_chan   src   set status and tempo updates
//
// A set reads and checks entries in turn (ST_SET_RD, ST_SET_CHK) until it claims one,
// then waits for the serial divider before writing; when the table is full it answers
// with a drop. A tick reads and updates every entry in turn, then sends any held update.
// Reset clears the entry valid bits at once; no sweep is needed.
// A stalled response holds the walk only when a second result is ready to leave.
`include "tempo_ramp_table_defines.svh"

module tempo_ramp_table #(
   parameter int NUM_ENTRIES = 16,
   parameter int NUM_SLOTS   = 4
) (
   input  logic      clock,
   input  logic      reset,
   trt_req_if.sink   req_chan,
   trt_rsp_if.source rsp_chan
);
   import trt_pkg::*;

   localparam int IDX_W = NUM_ENTRIES > 1 ? $clog2(NUM_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);
   localparam logic [4:0] MAX_CNT = 5'(MAX_RESULTS);

   function automatic logic slot_stopped(input logic [1:0] s, input logic [3:0] m);
      logic r;
      if (int'(s) >= NUM_SLOTS) begin
         r = 1'b1;
      end else begin
         r = m[s];
      end
      return r;
   endfunction

   state_type      state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [1:0]     slot_ff, slot_in;
   logic [4:0]     chan_ff, chan_in;
   logic [3:0]     mask_ff, mask_in;
   logic [15:0]    len_ff, len_in;
   logic [31:0]    t0_ff, t0_in;
   logic [31:0]    tg_ff, tg_in;
   logic           neg_ff, neg_in;
   logic [4:0]     cnt_ff, cnt_in;
   logic           hold_vld_ff, hold_vld_in;
   logic [1:0]     hold_slot_ff, hold_slot_in;
   logic [4:0]     hold_chan_ff, hold_chan_in;
   logic [23:0]    hold_tempo_ff, hold_tempo_in;
   logic           rsp_vld_ff, rsp_vld_in;
   kind_type       rsp_kind_ff, rsp_kind_in;
   logic [1:0]     rsp_slot_ff, rsp_slot_in;
   logic [4:0]     rsp_chan_ff, rsp_chan_in;
   logic [23:0]    rsp_tempo_ff, rsp_tempo_in;
   logic           rsp_last_ff, rsp_last_in;

   logic           out_free;
   logic           div_start;
   logic           div_busy;
   logic [31:0]    div_quo;
   logic [31:0]    mag;
   logic [32:0]    diff;
   logic [31:0]    q_fix;
   logic [32:0]    step;
   entry_type      rd_data;
   entry_type      wr_data;
   logic           wr_en;
   logic           claim;
   logic           move;
   logic           report;
   logic [33:0]    sum;
   logic [33:0]    tgt34;
   logic [31:0]    nxt;

   trt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mag),
      .divisor  ((len_ff == 16'd0) ? 16'd1 : len_ff),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   trt_table #(
      .NUM_ENTRIES (NUM_ENTRIES)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (idx_ff),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (idx_ff),
      .wr_data (wr_data)
   );

   assign out_free = !rsp_vld_ff || rsp_chan.ready;

   always_comb begin
      diff  = {1'b0, tg_ff} - {1'b0, t0_ff};
      mag   = diff[32] ? (t0_ff - tg_ff) : diff[31:0];
      q_fix = (div_quo == 32'd0 && t0_ff != tg_ff) ? 32'd1 : div_quo;
      step  = neg_ff ? (33'd0 - {1'b0, q_fix}) : {1'b0, q_fix};

      claim  = (rd_data.tempo == rd_data.target)
               || (rd_data.slot == slot_ff && rd_data.channel == chan_ff);
      move   = (rd_data.tempo != rd_data.target) && !slot_stopped(rd_data.slot, mask_ff);
      report = move && (cnt_ff < MAX_CNT);
      sum    = {2'b00, rd_data.tempo} + {rd_data.step[32], rd_data.step};
      tgt34  = {2'b00, rd_data.target};
      nxt    = sum[31:0];
      if (!rd_data.step[32]) begin
         if ($signed(sum) > $signed(tgt34)) begin
            nxt = rd_data.target;
         end
      end else begin
         if ($signed(sum) < $signed(tgt34)) begin
            nxt = rd_data.target;
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      slot_in       = slot_ff;
      chan_in       = chan_ff;
      mask_in       = mask_ff;
      len_in        = len_ff;
      t0_in         = t0_ff;
      tg_in         = tg_ff;
      neg_in        = neg_ff;
      cnt_in        = cnt_ff;
      hold_vld_in   = hold_vld_ff;
      hold_slot_in  = hold_slot_ff;
      hold_chan_in  = hold_chan_ff;
      hold_tempo_in = hold_tempo_ff;
      rsp_vld_in    = rsp_vld_ff && !rsp_chan.ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_chan_in   = rsp_chan_ff;
      rsp_tempo_in  = rsp_tempo_ff;
      rsp_last_in   = rsp_last_ff;
      div_start     = 1'b0;
      wr_en         = 1'b0;
      wr_data       = rd_data;
      req_chan.ready = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               slot_in = req_chan.slot;
               chan_in = req_chan.channel;
               mask_in = req_chan.stopped_mask;
               len_in  = req_chan.ramp_halfframes;
               if (req_chan.channel != WHOLE_CHANNEL
                   && slot_stopped(req_chan.slot, req_chan.stopped_mask)) begin
                  t0_in = STOPPED_START;
               end else begin
                  t0_in = {req_chan.start_tempo, 8'h00};
               end
               tg_in       = {req_chan.goal_tempo, 8'h00};
               idx_in      = '0;
               cnt_in      = '0;
               hold_vld_in = 1'b0;
               if (req_chan.func == FUNC_TICK) begin
                  state_in = ST_TICK_RD;
               end else begin
                  state_in = ST_SET_PREP;
               end
            end
         end
         ST_SET_PREP: begin
            div_start = 1'b1;
            neg_in    = diff[32];
            state_in  = ST_SET_RD;
         end
         ST_SET_RD: begin
            state_in = ST_SET_CHK;
         end
         ST_SET_CHK: begin
            if (claim) begin
               state_in = ST_SET_WAIT;
            end else if (idx_ff == LAST_IDX) begin
               state_in = ST_SET_DROP;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_SET_RD;
            end
         end
         ST_SET_WAIT: begin
            if (!div_busy && out_free) begin
               wr_en          = 1'b1;
               wr_data.slot    = slot_ff;
               wr_data.channel = chan_ff;
               wr_data.tempo   = t0_ff;
               wr_data.target  = tg_ff;
               wr_data.step    = step;
               rsp_vld_in     = 1'b1;
               rsp_kind_in    = KIND_SET_OK;
               rsp_slot_in    = slot_ff;
               rsp_chan_in    = chan_ff;
               rsp_tempo_in   = t0_ff[31:8];
               rsp_last_in    = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_SET_DROP: begin
            if (out_free) begin
               rsp_vld_in   = 1'b1;
               rsp_kind_in  = KIND_SET_DROP;
               rsp_slot_in  = slot_ff;
               rsp_chan_in  = chan_ff;
               rsp_tempo_in = '0;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_TICK_RD: begin
            state_in = ST_TICK_UPD;
         end
         ST_TICK_UPD: begin
            if (!(report && hold_vld_ff && !out_free)) begin
               if (move) begin
                  wr_en         = 1'b1;
                  wr_data.tempo = nxt;
               end
               if (report) begin
                  if (hold_vld_ff) begin
                     rsp_vld_in   = 1'b1;
                     rsp_kind_in  = KIND_UPDATE;
                     rsp_slot_in  = hold_slot_ff;
                     rsp_chan_in  = hold_chan_ff;
                     rsp_tempo_in = hold_tempo_ff;
                     rsp_last_in  = 1'b0;
                  end
                  hold_vld_in   = 1'b1;
                  hold_slot_in  = rd_data.slot;
                  hold_chan_in  = rd_data.channel;
                  hold_tempo_in = nxt[31:8];
                  cnt_in        = cnt_ff + 5'd1;
               end
               if (idx_ff == LAST_IDX) begin
                  state_in = ST_TICK_END;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_TICK_RD;
               end
            end
         end
         ST_TICK_END: begin
            if (!hold_vld_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_vld_in   = 1'b1;
               rsp_kind_in  = KIND_UPDATE;
               rsp_slot_in  = hold_slot_ff;
               rsp_chan_in  = hold_chan_ff;
               rsp_tempo_in = hold_tempo_ff;
               rsp_last_in  = 1'b1;
               hold_vld_in  = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         idx_ff      <= '0;
         cnt_ff      <= '0;
         hold_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         cnt_ff      <= cnt_in;
         hold_vld_ff <= hold_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
      slot_ff       <= slot_in;
      chan_ff       <= chan_in;
      mask_ff       <= mask_in;
      len_ff        <= len_in;
      t0_ff         <= t0_in;
      tg_ff         <= tg_in;
      neg_ff        <= neg_in;
      hold_slot_ff  <= hold_slot_in;
      hold_chan_ff  <= hold_chan_in;
      hold_tempo_ff <= hold_tempo_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_chan_ff   <= rsp_chan_in;
      rsp_tempo_ff  <= rsp_tempo_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_chan.valid       = rsp_vld_ff;
   assign rsp_chan.kind        = rsp_kind_ff;
   assign rsp_chan.out_slot    = rsp_slot_ff;
   assign rsp_chan.out_channel = rsp_chan_ff;
   assign rsp_chan.new_tempo   = rsp_tempo_ff;
   assign rsp_chan.last        = rsp_last_ff;

   `TRT_ASSERT(a_cnt_cap, clock, reset, cnt_ff <= MAX_CNT, "reported count past cap")
   `TRT_ASSERT(a_hold_tick, clock, reset, !hold_vld_ff || state_ff == ST_TICK_RD || state_ff == ST_TICK_UPD || state_ff == ST_TICK_END, "held update outside tick")
   `TRT_ASSERT(a_set_last, clock, reset, !rsp_vld_ff || rsp_kind_ff == KIND_UPDATE || rsp_last_ff, "set status without last")
   `TRT_ASSERT_NEXT(a_prep_div, clock, reset, state_ff == ST_SET_PREP, div_busy, "divider not started")

endmodule

### test/tb_top.sv
// Self-checking testbench for tempo_ramp_table: drives set and tick requests with random gaps
// and response stalls, and checks every response against its own ramp table predictor.
// Depends on trt_pkg, trt_if and the tempo_ramp_table design files.
module tb_top;
   import trt_pkg::*;

   localparam int NUM_ENTRIES  = 16;
   localparam int RANDOM_ITEMS = 150;
   localparam int DRAIN_CYCLES = 100;
   localparam int LIMIT_CYCLES = 600000;

   typedef struct {
      logic        func;
      logic [1:0]  slot;
      logic [4:0]  channel;
      logic [23:0] start_tempo;
      logic [23:0] goal_tempo;
      logic [15:0] ramp_halfframes;
      logic [3:0]  stopped_mask;
   } ramp_req_type;

   typedef struct {
      kind_type    kind;
      logic [1:0]  slot;
      logic [4:0]  channel;
      logic [23:0] tempo;
      logic        last;
   } ramp_rsp_type;

   logic clock;
   logic reset;

   trt_req_if req_bus();
   trt_rsp_if rsp_bus();

   tempo_ramp_table i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   logic [1:0]         ent_slot    [NUM_ENTRIES];
   logic [4:0]         ent_channel [NUM_ENTRIES];
   logic [31:0]        ent_tempo   [NUM_ENTRIES];
   logic [31:0]        ent_target  [NUM_ENTRIES];
   logic signed [32:0] ent_step    [NUM_ENTRIES];

   ramp_rsp_type pending_tempo_rsp[$];
   int unsigned  mismatch_count = 0;
   int unsigned  cycle_count = 0;
   bit           no_idle = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= LIMIT_CYCLES);
      $display("** tempo_ramp_table: FAILED **");
      $finish;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic signed [32:0] ramp_step(logic [31:0] from, logic [31:0] to,
                                                    logic [15:0] len);
      logic [31:0] mag;
      logic [31:0] quot;
      logic [31:0] div;
      mag  = (to < from) ? from - to : to - from;
      div  = (len == 16'd0) ? 32'd1 : {16'd0, len};
      quot = mag / div;
      if (quot == 32'd0 && mag != 32'd0) quot = 32'd1;
      return (to < from) ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
   endfunction

   function automatic void predict_tempo_rsp(ramp_req_type r);
      ramp_rsp_type batch[$];
      ramp_rsp_type rsp;
      logic [31:0]  t0;
      logic [31:0]  tg;
      longint       nxt;
      int           claim;
      if (r.func == FUNC_SET) begin
         t0 = (r.channel != WHOLE_CHANNEL && r.stopped_mask[r.slot]) ? STOPPED_START
                                                                    : {r.start_tempo, 8'h00};
         tg = {r.goal_tempo, 8'h00};
         claim = -1;
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            if (claim < 0 && (ent_tempo[i] == ent_target[i] ||
                              (ent_slot[i] == r.slot && ent_channel[i] == r.channel)))
               claim = i;
         end
         rsp.slot    = r.slot;
         rsp.channel = r.channel;
         rsp.last    = 1'b1;
         if (claim >= 0) begin
            ent_slot[claim]    = r.slot;
            ent_channel[claim] = r.channel;
            ent_tempo[claim]   = t0;
            ent_target[claim]  = tg;
            ent_step[claim]    = ramp_step(t0, tg, r.ramp_halfframes);
            rsp.kind  = KIND_SET_OK;
            rsp.tempo = t0[31:8];
         end else begin
            rsp.kind  = KIND_SET_DROP;
            rsp.tempo = 24'd0;
         end
         batch.push_back(rsp);
      end else begin
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            if (ent_tempo[i] != ent_target[i] && !r.stopped_mask[ent_slot[i]]) begin
               nxt = longint'(ent_tempo[i]) + longint'(ent_step[i]);
               if (ent_step[i] >= 0) begin
                  if (nxt > longint'(ent_target[i])) nxt = longint'(ent_target[i]);
               end else if (nxt < longint'(ent_target[i])) begin
                  nxt = longint'(ent_target[i]);
               end
               if (nxt < 0) nxt = 0;
               if (nxt > 64'hFFFF_FFFF) nxt = 64'hFFFF_FFFF;
               ent_tempo[i] = nxt[31:0];
               if (batch.size() < MAX_RESULTS) begin
                  rsp.kind    = KIND_UPDATE;
                  rsp.slot    = ent_slot[i];
                  rsp.channel = ent_channel[i];
                  rsp.tempo   = ent_tempo[i][31:8];
                  rsp.last    = 1'b0;
                  batch.push_back(rsp);
               end
            end
         end
         if (batch.size() > 0) batch[$].last = 1'b1;
      end
      foreach (batch[k]) pending_tempo_rsp.push_back(batch[k]);
   endfunction

   function automatic ramp_req_type make_set(logic [1:0] s, logic [4:0] c, logic [23:0] st,
                                             logic [23:0] tg, logic [15:0] len,
                                             logic [3:0] mask);
      ramp_req_type r;
      r.func            = FUNC_SET;
      r.slot            = s;
      r.channel         = c;
      r.start_tempo     = st;
      r.goal_tempo      = tg;
      r.ramp_halfframes = len;
      r.stopped_mask    = mask;
      return r;
   endfunction

   function automatic ramp_req_type make_tick(logic [3:0] mask);
      ramp_req_type r;
      r.func            = FUNC_TICK;
      r.slot            = 2'($urandom_range(0, 3));
      r.channel         = 5'($urandom_range(0, 31));
      r.start_tempo     = 24'($urandom);
      r.goal_tempo      = 24'($urandom);
      r.ramp_halfframes = 16'($urandom);
      r.stopped_mask    = mask;
      return r;
   endfunction

   function automatic bit pair_known(logic [1:0] s, logic [4:0] c);
      foreach (ent_slot[i])
         if (ent_slot[i] == s && ent_channel[i] == c) return 1'b1;
      return 1'b0;
   endfunction

   task automatic send_ramp_req(input ramp_req_type r);
      int gap;
      req_bus.valid           <= 1'b1;
      req_bus.func            <= r.func;
      req_bus.slot            <= r.slot;
      req_bus.channel         <= r.channel;
      req_bus.start_tempo     <= r.start_tempo;
      req_bus.goal_tempo      <= r.goal_tempo;
      req_bus.ramp_halfframes <= r.ramp_halfframes;
      req_bus.stopped_mask    <= r.stopped_mask;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_tempo_rsp(r);
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic test_set_extremes();
      send_ramp_req(make_set(2'd0, 5'd0, 24'd0, 24'hFFFFFF, 16'd0, 4'h0));
      send_ramp_req(make_set(2'd1, WHOLE_CHANNEL, 24'hFFFFFF, 24'd0, 16'hFFFF, 4'hF));
      send_ramp_req(make_set(2'd2, 5'd5, 24'd1000, 24'd50, 16'd3, 4'b0100));
      send_ramp_req(make_set(2'd3, 5'd31, 24'd100, 24'd101, 16'hFFFF, 4'h0));
      send_ramp_req(make_set(2'd3, 5'd17, 24'd200, 24'd200, 16'd5, 4'h0));
      send_ramp_req(make_set(2'd2, 5'd5, 24'd500, 24'd499, 16'hFFFF, 4'h0));
      send_ramp_req(make_set(2'd0, 5'd0, 24'h123456, 24'hEDCBA9, 16'h8000, 4'b0001));
   endtask

   task automatic test_tick_masks();
      send_ramp_req(make_tick(4'h0));
      send_ramp_req(make_tick(4'b1010));
      send_ramp_req(make_tick(4'hF));
      send_ramp_req(make_tick(4'b0101));
      send_ramp_req(make_tick(4'h0));
   endtask

   task automatic test_table_full();
      int          busy;
      logic [1:0]  s;
      logic [4:0]  c;
      logic [23:0] st;
      busy = 0;
      foreach (ent_tempo[i])
         if (ent_tempo[i] != ent_target[i]) busy++;
      s = 2'd0;
      c = 5'd0;
      // fill every idle entry, then one more set that finds no room
      for (int k = busy; k <= NUM_ENTRIES; k++) begin
         while (pair_known(s, c)) {s, c} = {s, c} + 7'd1;
         st = 24'($urandom);
         send_ramp_req(make_set(s, c, st, st + 24'd1 + 24'($urandom_range(0, 999)), 16'd2,
                                4'h0));
      end
      repeat (2) send_ramp_req(make_tick(4'h0));
   endtask

   task automatic test_random_traffic();
      logic [1:0]  s;
      logic [4:0]  c;
      logic [23:0] st;
      logic [23:0] tg;
      logic [15:0] len;
      logic [3:0]  mask;
      int          sel;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 25 == 0) no_idle = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 99) < 45) begin
            mask = ($urandom_range(0, 2) == 0) ? 4'($urandom) : 4'h0;
            send_ramp_req(make_tick(mask));
         end else begin
            s   = 2'($urandom_range(0, 3));
            sel = $urandom_range(0, 19);
            if (sel < 12) c = (sel % 4 == 3) ? WHOLE_CHANNEL : 5'(sel % 4);
            else if (sel < 17) c = 5'($urandom_range(0, 16));
            else c = 5'($urandom_range(0, 31));
            st  = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 400));
            tg  = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 400));
            if ($urandom_range(0, 9) == 0) tg = st;
            sel = $urandom_range(0, 9);
            if (sel < 7) len = 16'($urandom_range(0, 6));
            else if (sel < 9) len = 16'($urandom_range(7, 64));
            else len = 16'($urandom);
            mask = $urandom_range(0, 1) ? 4'h0 : 4'($urandom);
            send_ramp_req(make_set(s, c, st, tg, len, mask));
         end
      end
      no_idle = 0;
   endtask

   initial begin : rsp_ready_gen
      int stall_left;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) stall_left--;
         else stall_left = pick_gap();
         rsp_bus.ready <= (stall_left == 0);
      end
   end

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : rsp_checker
      ramp_rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_tempo_rsp.size() == 0) begin
            $error("unexpected response transfer: kind %0d slot %0d channel %0d tempo %0d",
                   rsp_bus.kind, rsp_bus.out_slot, rsp_bus.out_channel, rsp_bus.new_tempo);
            mismatch_count++;
         end else begin
            want = pending_tempo_rsp.pop_front();
            check_field("kind", 32'(want.kind), 32'(rsp_bus.kind));
            check_field("out_slot", 32'(want.slot), 32'(rsp_bus.out_slot));
            check_field("out_channel", 32'(want.channel), 32'(rsp_bus.out_channel));
            check_field("new_tempo", 32'(want.tempo), 32'(rsp_bus.new_tempo));
            check_field("last", 32'(want.last), 32'(rsp_bus.last));
         end
      end
   end

   initial begin
      reset                   <= 1'b1;
      req_bus.valid           <= 1'b0;
      req_bus.func            <= FUNC_SET;
      req_bus.slot            <= 2'd0;
      req_bus.channel         <= 5'd0;
      req_bus.start_tempo     <= 24'd0;
      req_bus.goal_tempo      <= 24'd0;
      req_bus.ramp_halfframes <= 16'd0;
      req_bus.stopped_mask    <= 4'h0;
      foreach (ent_slot[i]) begin
         ent_slot[i]    = 2'd0;
         ent_channel[i] = 5'd0;
         ent_tempo[i]   = 32'd0;
         ent_target[i]  = 32'd0;
         ent_step[i]    = 33'sd0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_set_extremes();
      test_tick_masks();
      test_table_full();
      test_random_traffic();

      req_bus.valid <= 1'b0;
      while (pending_tempo_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_tempo_rsp.size() == 0) begin
         $display("** tempo_ramp_table: PASSED **");
      end else begin
         $display("** tempo_ramp_table: FAILED **");
      end
      $finish;
   end

endmodule
